// ----- src/hhe_pkg.sv -----
package hhe_pkg;

   // Default size of the host value store, in bytes.
   localparam int HOST_MAX_DEF = 64;

   // Host limit register.
   localparam int              LIMIT_W        = 7;
   localparam logic [LIMIT_W-1:0] HOST_LIMIT_RST = 7'd63;

   // Pending blank counter saturates at its all-ones value.
   localparam int              PEND_W   = 7;
   localparam logic [PEND_W-1:0] PEND_SAT = '1;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_HOST_LIMIT = 1'b0;

   // Command queue between the parser and the host unit (power of two).
   localparam int CMDQ_DEPTH = 4;

   // Length of the header name without its colon.
   localparam int NAME_LEN = 4;

   // Character codes.
   localparam logic [7:0] CHR_CR      = 8'h0d;
   localparam logic [7:0] CHR_LF      = 8'h0a;
   localparam logic [7:0] CHR_SP      = 8'h20;
   localparam logic [7:0] CHR_TAB     = 8'h09;
   localparam logic [7:0] CHR_COLON   = 8'h3a;
   localparam logic [7:0] CHR_LBRACK  = 8'h5b;
   localparam logic [7:0] CHR_RBRACK  = 8'h5d;
   localparam logic [7:0] CHR_UPPER_A = 8'h41;
   localparam logic [7:0] CHR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CASE_BIT    = 8'h20;

   typedef enum logic [1:0] {
      CMD_CHAR,
      CMD_SPACE,
      CMD_FINISH,
      CMD_FAIL
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       request_end;
   } req_type;

   typedef struct packed {
      logic [7:0] host_char;
      logic       found;
      logic       last_char;
   } rsp_type;

   // Lowercase text of the header name.
   function automatic logic [7:0] name_char(input logic [1:0] idx);
      logic [7:0] c;
      unique case (idx)
         2'd0: c = 8'h68;
         2'd1: c = 8'h6f;
         2'd2: c = 8'h73;
         2'd3: c = 8'h74;
         default: c = 8'h74;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      logic [7:0] r;
      if (b >= CHR_UPPER_A && b <= CHR_UPPER_Z) begin
         r = b + CASE_BIT;
      end else begin
         r = b;
      end
      return r;
   endfunction

endpackage

// ----- src/http_host_header_extractor.sv -----
// Channel   Direction  Handshake          Word
// req_      in         req_valid/ready    data_byte, request_end
// rsp_      out        rsp_valid/ready    host_char, found, last_char
// csr_      in/out     APB, pready = 1    host_limit at byte address 0
//
// The parser takes one request byte per cycle while the command queue has
// room. A CR that turns out not to be followed by LF is replayed as line
// content before the byte after it, which waits meanwhile. Host bytes travel
// through a four-entry command queue to the host unit, which writes one byte
// per cycle into the value store; a run of blanks that is kept inside the
// value is written there one space per cycle when the next non-blank byte
// arrives, so the blanks stall the parser only when the queue fills. At the
// end of the host line the host unit reads the store and sends one result
// word per cycle while the result channel takes them. Reset is synchronous
// and needs no clearing pass: the store is only read at entries written in
// the same request. The result register lets the host unit keep working
// while a finished word waits for rsp_ready; a stalled result channel holds
// the host unit, then the queue, then the request channel.
module http_host_header_extractor #(
   parameter int HOST_MAX = hhe_pkg::HOST_MAX_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  hhe_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output hhe_pkg::rsp_type               rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [hhe_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [hhe_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [hhe_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   import hhe_pkg::*;

   logic [LIMIT_W-1:0] host_limit_ff, host_limit_in;
   logic               limit_sel;
   logic               csr_wr;

   logic               cmd_push;
   cmd_type            cmd_in;
   logic               cmd_full;
   logic               cmd_pop;
   logic               cmd_valid;
   cmd_type            cmd_head;

   // Registers sit at word addresses; the low two address bits are ignored.
   assign limit_sel = (csr_paddr[CSR_ADDR_W-1:2] == REG_HOST_LIMIT);
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && limit_sel;
   assign csr_pready = 1'b1;
   assign csr_prdata = limit_sel ? CSR_DATA_W'(host_limit_ff) : '0;

   assign host_limit_in = csr_wr ? csr_pwdata[LIMIT_W-1:0] : host_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         host_limit_ff <= HOST_LIMIT_RST;
      end else begin
         host_limit_ff <= host_limit_in;
      end
   end

   // Line splitter and header-name matcher.
   hhe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in)
   );

   // Decouples the parser from the host unit.
   hhe_cmd_fifo u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .not_empty (cmd_valid),
      .head      (cmd_head)
   );

   // Trims, stores and checks the host value, then sends the result words.
   hhe_back #(
      .HOST_MAX (HOST_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .host_limit (host_limit_ff),
      .cmd_valid  (cmd_valid),
      .cmd_head   (cmd_head),
      .cmd_pop    (cmd_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- src/hhe_ram.sv -----
module hhe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/hhe_front.sv -----
module hhe_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hhe_pkg::req_type req_data,
   input  logic             cmd_full,
   output logic             cmd_push,
   output hhe_pkg::cmd_type cmd_data
);

   import hhe_pkg::*;

   localparam logic [2:0] PH_LINE_START = 3'd0;
   localparam logic [2:0] PH_OTHER_LINE = 3'd1;
   localparam logic [2:0] PH_HOST_LEAD  = 3'd2;
   localparam logic [2:0] PH_HOST_VALUE = 3'd3;
   localparam logic [2:0] PH_DONE       = 3'd4;

   logic [2:0] phase_ff, phase_in;
   logic [2:0] pos_ff, pos_in;
   logic       pend_cr_ff, pend_cr_in;

   logic       is_end;
   logic       live;
   logic       inject;
   logic       accept;
   logic       content_en;
   logic [7:0] cb;
   logic       blank;
   logic       name_ok;

   assign is_end = req_data.request_end || (req_data.data_byte == 8'd0);
   assign live   = (phase_ff != PH_DONE);
   // A held CR that is not followed by LF is line content; it is replayed
   // on its own cycle before the byte that follows it.
   assign inject = req_valid && !is_end && live && pend_cr_ff
                   && (req_data.data_byte != CHR_LF);
   assign req_ready = !cmd_full && !inject;
   assign accept    = req_valid && req_ready;

   assign cb      = inject ? CHR_CR : req_data.data_byte;
   assign blank   = (cb == CHR_SP) || (cb == CHR_TAB);
   assign name_ok = (pos_ff < 3'(NAME_LEN)) ? ((cb | CASE_BIT) == name_char(pos_ff[1:0]))
                                            : (cb == CHR_COLON);

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      pend_cr_in    = pend_cr_ff;
      content_en    = 1'b0;
      cmd_push      = 1'b0;
      cmd_data.op   = CMD_FAIL;
      cmd_data.data = 8'd0;

      if (inject && !cmd_full) begin
         content_en = 1'b1;
         pend_cr_in = 1'b0;
      end else if (accept) begin
         priority if (is_end) begin
            if (live) begin
               cmd_push    = 1'b1;
               cmd_data.op = CMD_FAIL;
            end
            phase_in   = PH_LINE_START;
            pos_in     = 3'd0;
            pend_cr_in = 1'b0;
         end else if (!live) begin
            phase_in = PH_DONE;
         end else if (req_data.data_byte == CHR_CR) begin
            pend_cr_in = 1'b1;
         end else if (pend_cr_ff) begin
            // Only LF gets here with a held CR: the line ends.
            pend_cr_in = 1'b0;
            priority if (phase_ff == PH_LINE_START && pos_ff == 3'd0) begin
               phase_in    = PH_DONE;
               cmd_push    = 1'b1;
               cmd_data.op = CMD_FAIL;
            end else if (phase_ff == PH_HOST_LEAD || phase_ff == PH_HOST_VALUE) begin
               phase_in    = PH_DONE;
               cmd_push    = 1'b1;
               cmd_data.op = CMD_FINISH;
            end else begin
               phase_in = PH_LINE_START;
               pos_in   = 3'd0;
            end
         end else begin
            content_en = 1'b1;
         end
      end

      if (content_en) begin
         unique case (phase_ff)
            PH_LINE_START: begin
               pos_in = pos_ff + 3'd1;
               if (!name_ok) begin
                  phase_in = PH_OTHER_LINE;
               end else if (pos_ff == 3'(NAME_LEN)) begin
                  phase_in = PH_HOST_LEAD;
               end
            end
            PH_HOST_LEAD: begin
               if (!blank) begin
                  phase_in      = PH_HOST_VALUE;
                  cmd_push      = 1'b1;
                  cmd_data.op   = CMD_CHAR;
                  cmd_data.data = to_lower(cb);
               end
            end
            PH_HOST_VALUE: begin
               cmd_push      = 1'b1;
               cmd_data.op   = blank ? CMD_SPACE : CMD_CHAR;
               cmd_data.data = to_lower(cb);
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LINE_START;
         pos_ff     <= 3'd0;
         pend_cr_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         pend_cr_ff <= pend_cr_in;
      end
   end

endmodule

// ----- src/hhe_cmd_fifo.sv -----
module hhe_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hhe_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output hhe_pkg::cmd_type head
);

   import hhe_pkg::*;

   localparam int PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type            entry_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(CMDQ_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CMDQ_DEPTH))
      else $error("command queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("command popped from an empty queue");

endmodule

// ----- src/hhe_back.sv -----
module hhe_back #(
   parameter int HOST_MAX = hhe_pkg::HOST_MAX_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [hhe_pkg::LIMIT_W-1:0]  host_limit,
   input  logic                         cmd_valid,
   input  hhe_pkg::cmd_type             cmd_head,
   output logic                         cmd_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output hhe_pkg::rsp_type             rsp_data
);

   import hhe_pkg::*;

   localparam int ADDR_W = $clog2(HOST_MAX);
   localparam int CNT_W  = $clog2(HOST_MAX + 1);
   localparam int SUM_W  = LIMIT_W + 1;

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_FILL = 2'd1;
   localparam logic [1:0] B_EMIT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  stored_ff, stored_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic              too_long_ff, too_long_in;
   logic              colon_vld_ff, colon_vld_in;
   logic [ADDR_W-1:0] colon_pos_ff, colon_pos_in;
   logic              close_vld_ff, close_vld_in;
   logic [ADDR_W-1:0] close_pos_ff, close_pos_in;
   logic              bracket_ff, bracket_in;
   logic [7:0]        char_ff, char_in;
   logic [ADDR_W-1:0] emit_idx_ff, emit_idx_in;
   logic [ADDR_W-1:0] emit_end_ff, emit_end_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [7:0]        wr_data;
   logic [7:0]        rd_data;
   logic              clr;
   logic              out_free;
   logic [LIMIT_W-1:0] limit_eff;
   logic [SUM_W-1:0]  len_sum;
   logic              commit_over;
   logic [CNT_W-1:0]  n_plain;
   logic              finish_fail;
   logic [ADDR_W-1:0] finish_start;
   logic [ADDR_W-1:0] finish_end;
   logic              is_last;

   hhe_ram #(
      .WIDTH (8),
      .DEPTH (HOST_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (stored_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (emit_idx_in),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign limit_eff = (host_limit > LIMIT_W'(HOST_MAX)) ? LIMIT_W'(HOST_MAX) : host_limit;
   assign len_sum   = SUM_W'(stored_ff) + SUM_W'(pend_ff) + SUM_W'(1);
   assign commit_over = (len_sum > SUM_W'(limit_eff));

   assign n_plain = colon_vld_ff ? CNT_W'(colon_pos_ff) : stored_ff;
   assign finish_fail = too_long_ff || (stored_ff == '0)
                        || (LIMIT_W'(stored_ff) > limit_eff)
                        || (bracket_ff ? (!close_vld_ff || close_pos_ff == ADDR_W'(1))
                                       : (n_plain == '0));
   assign finish_start = bracket_ff ? ADDR_W'(1) : '0;
   assign finish_end   = bracket_ff ? close_pos_ff - ADDR_W'(1)
                                    : ADDR_W'(n_plain - CNT_W'(1));
   assign is_last = (emit_idx_ff == emit_end_ff);

   always_comb begin
      state_in     = state_ff;
      stored_in    = stored_ff;
      pend_in      = pend_ff;
      too_long_in  = too_long_ff;
      colon_vld_in = colon_vld_ff;
      colon_pos_in = colon_pos_ff;
      close_vld_in = close_vld_ff;
      close_pos_in = close_pos_ff;
      bracket_in   = bracket_ff;
      char_in      = char_ff;
      emit_idx_in  = emit_idx_ff;
      emit_end_in  = emit_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_data      = CHR_SP;
      clr          = 1'b0;
      cmd_pop      = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (cmd_valid && (out_free || cmd_head.op == CMD_CHAR
                              || cmd_head.op == CMD_SPACE)) begin
               cmd_pop = 1'b1;
               unique case (cmd_head.op)
                  CMD_CHAR: begin
                     if (!too_long_ff) begin
                        priority if (commit_over) begin
                           too_long_in = 1'b1;
                        end else if (pend_ff == '0) begin
                           wr_en   = 1'b1;
                           wr_data = cmd_head.data;
                        end else begin
                           wr_en    = 1'b1;
                           pend_in  = pend_ff - PEND_W'(1);
                           char_in  = cmd_head.data;
                           state_in = B_FILL;
                        end
                     end
                  end
                  CMD_SPACE: begin
                     if (pend_ff != PEND_SAT) begin
                        pend_in = pend_ff + PEND_W'(1);
                     end
                  end
                  CMD_FAIL: begin
                     clr                   = 1'b1;
                     rsp_valid_in          = 1'b1;
                     rsp_data_in.host_char = 8'd0;
                     rsp_data_in.found     = 1'b0;
                     rsp_data_in.last_char = 1'b1;
                  end
                  CMD_FINISH: begin
                     clr = 1'b1;
                     if (finish_fail) begin
                        rsp_valid_in          = 1'b1;
                        rsp_data_in.host_char = 8'd0;
                        rsp_data_in.found     = 1'b0;
                        rsp_data_in.last_char = 1'b1;
                     end else begin
                        emit_idx_in = finish_start;
                        emit_end_in = finish_end;
                        state_in    = B_EMIT;
                     end
                  end
               endcase
            end
         end
         B_FILL: begin
            wr_en = 1'b1;
            if (pend_ff == '0) begin
               wr_data  = char_ff;
               state_in = B_IDLE;
            end else begin
               pend_in = pend_ff - PEND_W'(1);
            end
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.host_char = rd_data;
               rsp_data_in.found     = 1'b1;
               rsp_data_in.last_char = is_last;
               if (is_last) begin
                  state_in = B_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      if (wr_en) begin
         stored_in = stored_ff + CNT_W'(1);
         if (wr_data == CHR_COLON && !colon_vld_ff) begin
            colon_vld_in = 1'b1;
            colon_pos_in = stored_ff[ADDR_W-1:0];
         end
         if (wr_data == CHR_RBRACK && !close_vld_ff) begin
            close_vld_in = 1'b1;
            close_pos_in = stored_ff[ADDR_W-1:0];
         end
         if (stored_ff == '0) begin
            bracket_in = (wr_data == CHR_LBRACK);
         end
      end

      if (clr) begin
         stored_in    = '0;
         pend_in      = '0;
         too_long_in  = 1'b0;
         colon_vld_in = 1'b0;
         close_vld_in = 1'b0;
         bracket_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         stored_ff    <= '0;
         pend_ff      <= '0;
         too_long_ff  <= 1'b0;
         colon_vld_ff <= 1'b0;
         close_vld_ff <= 1'b0;
         bracket_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stored_ff    <= stored_in;
         pend_ff      <= pend_in;
         too_long_ff  <= too_long_in;
         colon_vld_ff <= colon_vld_in;
         close_vld_ff <= close_vld_in;
         bracket_ff   <= bracket_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      colon_pos_ff <= colon_pos_in;
      close_pos_ff <= close_pos_in;
      char_ff      <= char_in;
      emit_idx_ff  <= emit_idx_in;
      emit_end_ff  <= emit_end_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_EMIT) |-> (emit_idx_ff <= emit_end_ff))
      else $error("emit index ran past the end of the host name");

   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= CNT_W'(HOST_MAX))
      else $error("stored byte count above store size");

   a_fail_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found)
         |-> (rsp_data_ff.last_char && rsp_data_ff.host_char == 8'd0))
      else $error("fail word is not a single zero last word");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import hhe_pkg::*;

   // Size of the value store in the instance below, which keeps its default.
   localparam int STORE_DEPTH = HOST_MAX_DEF;
   // Position marker for "no colon or close bracket seen yet".
   localparam int NO_POS = 127;
   // The header name, first letter in the top byte.
   localparam logic [31:0] NAME_WORD = "host";
   // Byte addresses on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = CSR_ADDR_W'(4 * REG_HOST_LIMIT);
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR = CSR_ADDR_W'(4);

   // Where the line parser stands within one request.
   typedef enum logic [2:0] {
      LINE_START,
      SKIP_LINE,
      HOST_LEAD,
      HOST_VALUE,
      DECIDED
   } parse_phase_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   http_host_header_extractor uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // Idle rates of both sides in percent of cycles, and a long hold-off of the
   // result side that its own process counts down.
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_off_cycles = 0;

   int mismatches = 0;
   int words_offered = 0;

   // Result words that the host parser is expected to produce, oldest first.
   rsp_type host_words_due[$];

   // Shadow copy of the parser state and of the host limit register.
   logic [LIMIT_W-1:0] limit_shadow = HOST_LIMIT_RST;
   parse_phase_type    parse_phase;
   int                 line_pos;
   bit                 cr_held;
   logic [7:0]         value_mem [STORE_DEPTH];
   int                 kept_count;
   int                 blank_run;
   bit                 overflowed;
   int                 colon_at;
   int                 close_at;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // Host parser prediction.
   // ---------------------------------------------------------------------

   function automatic void new_request();
      parse_phase = LINE_START;
      line_pos    = 0;
      cr_held     = 1'b0;
      kept_count  = 0;
      blank_run   = 0;
      overflowed  = 1'b0;
      colon_at    = NO_POS;
      close_at    = NO_POS;
   endfunction

   // A limit above the store size behaves as the store size.
   function automatic int usable_limit();
      return (int'(limit_shadow) > STORE_DEPTH) ? STORE_DEPTH : int'(limit_shadow);
   endfunction

   function automatic void queue_fail();
      rsp_type r;
      r.host_char = 8'h00;
      r.found     = 1'b0;
      r.last_char = 1'b1;
      host_words_due.push_back(r);
   endfunction

   function automatic void store_value_byte(input logic [7:0] b);
      if (kept_count >= STORE_DEPTH) return;
      if (b == CHR_COLON && colon_at == NO_POS) colon_at = kept_count;
      if (b == CHR_RBRACK && close_at == NO_POS) close_at = kept_count;
      value_mem[kept_count] = b;
      kept_count++;
   endfunction

   // A non-blank value byte: the blanks held back before it are kept as
   // spaces, but only while the whole value still fits the limit.
   function automatic void keep_value_char(input logic [7:0] b);
      logic [7:0] c;
      if (overflowed) return;
      if (kept_count + blank_run + 1 > usable_limit()) begin
         overflowed = 1'b1;
         return;
      end
      while (blank_run > 0) begin
         store_value_byte(CHR_SP);
         blank_run--;
      end
      c = b;
      if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) c = c + CASE_BIT;
      store_value_byte(c);
   endfunction

   function automatic void line_content(input logic [7:0] b);
      bit blank;
      bit name_hit;
      blank = (b == CHR_SP || b == CHR_TAB);
      case (parse_phase)
         LINE_START: begin
            if (line_pos < NAME_LEN) begin
               name_hit = ((b | CASE_BIT) == NAME_WORD[31 - 8 * line_pos -: 8]);
            end else begin
               name_hit = (b == CHR_COLON);
            end
            line_pos++;
            if (!name_hit) begin
               parse_phase = SKIP_LINE;
            end else if (line_pos >= NAME_LEN + 1) begin
               parse_phase = HOST_LEAD;
            end
         end
         HOST_LEAD: begin
            if (!blank) begin
               parse_phase = HOST_VALUE;
               keep_value_char(b);
            end
         end
         HOST_VALUE: begin
            if (blank) begin
               if (blank_run < int'(PEND_SAT)) blank_run++;
            end else begin
               keep_value_char(b);
            end
         end
         default: begin
         end
      endcase
   endfunction

   // End of the host line: a bracketed value yields the text up to the first
   // close bracket, any other value the text up to the first colon.
   function automatic void finish_host_line();
      int first;
      int n;
      rsp_type r;
      if (overflowed || kept_count == 0 || kept_count > usable_limit()) begin
         queue_fail();
         return;
      end
      first = 0;
      if (value_mem[0] == CHR_LBRACK) begin
         if (close_at == NO_POS) begin
            queue_fail();
            return;
         end
         first = 1;
         n = close_at - 1;
      end else begin
         n = (colon_at == NO_POS) ? kept_count : colon_at;
      end
      if (n == 0 || first + n > STORE_DEPTH) begin
         queue_fail();
         return;
      end
      for (int i = 0; i < n; i++) begin
         r.host_char = value_mem[first + i];
         r.found     = 1'b1;
         r.last_char = (i == n - 1);
         host_words_due.push_back(r);
      end
   endfunction

   function automatic void predict_host_words(input req_type w);
      logic [7:0] b;
      b = w.data_byte;
      // Both the end flag and a zero byte close the request.
      if (w.request_end || b == 8'h00) begin
         if (parse_phase != DECIDED) queue_fail();
         new_request();
         return;
      end
      if (parse_phase == DECIDED) return;
      // A CR waits to see whether LF follows; if not, it is line content.
      if (b == CHR_CR) begin
         if (cr_held) line_content(CHR_CR);
         cr_held = 1'b1;
         return;
      end
      if (b == CHR_LF && cr_held) begin
         cr_held = 1'b0;
         if (parse_phase == LINE_START && line_pos == 0) begin
            parse_phase = DECIDED;
            queue_fail();
            return;
         end
         if (parse_phase == HOST_LEAD || parse_phase == HOST_VALUE) begin
            parse_phase = DECIDED;
            finish_host_line();
            return;
         end
         parse_phase = LINE_START;
         line_pos    = 0;
         return;
      end
      if (cr_held) begin
         cr_held = 1'b0;
         line_content(CHR_CR);
      end
      line_content(b);
   endfunction

   // ---------------------------------------------------------------------
   // Result side: random readiness, the long hold-off, and the checker.
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_off_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Outputs are read right after the edge, before any register in the block
   // takes its new value, so each accepted word is seen exactly once.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (host_words_due.size() == 0) begin
            report_mismatch($sformatf("result word %h with nothing expected", rsp_data));
         end else begin
            want = host_words_due.pop_front();
            if (rsp_data.host_char !== want.host_char)
               report_mismatch($sformatf("host_char %h, expected %h",
                                         rsp_data.host_char, want.host_char));
            if (rsp_data.found !== want.found)
               report_mismatch($sformatf("found %b, expected %b",
                                         rsp_data.found, want.found));
            if (rsp_data.last_char !== want.last_char)
               report_mismatch($sformatf("last_char %b, expected %b",
                                         rsp_data.last_char, want.last_char));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side. Every task here starts and ends just after a rising edge.
   // ---------------------------------------------------------------------

   // Offer one word, after a random idle gap, and hold it until accepted.
   // Valid stays high afterwards so that the next word can follow at once.
   task automatic send_word(input req_type w);
      int gap;
      gap = 0;
      while (gap < 60 && $urandom_range(99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      // Bytes after the decision are merely skipped and do not count.
      if (parse_phase != DECIDED) words_offered++;
      predict_host_words(w);
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_type w;
      w.data_byte   = b;
      w.request_end = 1'b0;
      send_word(w);
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   task automatic send_crlf();
      send_byte(CHR_CR);
      send_byte(CHR_LF);
   endtask

   // Close the request either with the end flag or with a zero byte.
   task automatic send_end(input bit by_zero);
      req_type w;
      w.request_end = !by_zero;
      w.data_byte   = by_zero ? 8'h00 : 8'($urandom_range(255));
      send_word(w);
   endtask

   task automatic send_host_of_length(input int n);
      send_text("Host: ");
      for (int i = 0; i < n; i++) send_byte(8'("a" + i % 26));
      send_crlf();
      send_end(1'b0);
   endtask

   // Let the block drain: no word offered, every expected result seen, and
   // then a further wait for anything still inside.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (host_words_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, then access until pready.
   task automatic csr_access(input bit wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_limit_readback();
      logic [CSR_DATA_W-1:0] got;
      csr_access(1'b0, LIMIT_ADDR, '0, got);
      if (got !== CSR_DATA_W'(limit_shadow))
         report_mismatch($sformatf("host limit reads %0d, expected %0d", got, limit_shadow));
   endtask

   // Write a register once the block is idle; only the host limit exists.
   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr, input int value);
      logic [CSR_DATA_W-1:0] unused_read;
      wait_idle();
      csr_access(1'b1, addr, CSR_DATA_W'(value), unused_read);
      if (addr == LIMIT_ADDR) limit_shadow = LIMIT_W'(value);
      check_limit_readback();
   endtask

   // ---------------------------------------------------------------------
   // Random request content.
   // ---------------------------------------------------------------------

   function automatic logic [7:0] random_blank();
      return $urandom_range(1) ? CHR_SP : CHR_TAB;
   endfunction

   function automatic logic [7:0] random_host_byte();
      int pick;
      logic [7:0] c;
      pick = $urandom_range(99);
      if (pick < 60) begin
         c = 8'("a" + $urandom_range(25));
         if ($urandom_range(1)) c = c - CASE_BIT;
      end else if (pick < 75) c = 8'("0" + $urandom_range(9));
      else if (pick < 82) c = ".";
      else if (pick < 86) c = "-";
      else if (pick < 90) c = CHR_COLON;
      else if (pick < 94) c = random_blank();
      else if (pick < 97) c = CHR_RBRACK;
      else c = 8'($urandom_range(1, 255));
      return c;
   endfunction

   task automatic send_other_line();
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(32, 126)));
      send_crlf();
   endtask

   // The header name in random letter case, now and then slightly wrong.
   task automatic send_header_name();
      logic [7:0] c;
      for (int i = 0; i < NAME_LEN; i++) begin
         c = NAME_WORD[31 - 8 * i -: 8];
         if ($urandom_range(1)) c = c - CASE_BIT;
         if ($urandom_range(24) == 0) c = 8'($urandom_range(32, 126));
         send_byte(c);
      end
      send_byte(($urandom_range(24) == 0) ? CHR_SP : CHR_COLON);
   endtask

   // Mostly well formed requests with random headers and host values; the
   // rest are broken lines or plain noise.
   task automatic send_random_request();
      int  kind;
      int  len;
      bit  bracket;
      kind = $urandom_range(99);
      if (kind < 12) begin
         repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(0, 2)) send_other_line();
         if (kind < 18) send_crlf();
         send_header_name();
         repeat ($urandom_range(0, 3)) send_byte(random_blank());
         len = ($urandom_range(9) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
         bracket = ($urandom_range(4) == 0);
         if (bracket) send_byte(CHR_LBRACK);
         for (int i = 0; i < len; i++) send_byte(random_host_byte());
         if (bracket && $urandom_range(3) != 0) begin
            send_byte(CHR_RBRACK);
            if ($urandom_range(1)) send_text(":8080");
         end
         repeat ($urandom_range(0, 3)) send_byte(random_blank());
         if (kind < 25) begin
            // A lone CR is line content, and the line is never finished.
            send_byte(CHR_CR);
            if ($urandom_range(1)) send_byte(8'($urandom_range(32, 126)));
         end else begin
            send_crlf();
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(1, 255)));
         end
      end
      send_end($urandom_range(1));
   endtask

   // The limit is drawn so that both ends of the range come up often.
   function automatic int random_limit();
      int pick;
      pick = $urandom_range(9);
      case (pick)
         0: return 0;
         1: return 1;
         2: return STORE_DEPTH;
         3: return (1 << LIMIT_W) - 1;
         4: return STORE_DEPTH - 1;
         default: return $urandom_range(2, (1 << LIMIT_W) - 1);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   task automatic test_reset_limit();
      check_limit_readback();
   endtask

   // Header forms under the reset limit: trimming, lowercasing, the colon
   // and bracket cuts, lone and doubled CR, empty lines and values, missing
   // line ends, bytes with the top bit set, and bytes after the decision.
   task automatic test_header_forms();
      send_text("hOsT:  Ab:80 \015\012");
      send_text("tail");
      send_end(1'b0);
      send_crlf();
      send_end(1'b1);
      send_text("x-y: 1\015\012Host:[::1]:8\015\012");
      send_end(1'b0);
      send_text("Host:[ab\015\012");
      send_end(1'b1);
      send_text("Host: \t \015\012");
      send_end(1'b0);
      send_text("Host:a\015b\015\012");
      send_end(1'b1);
      send_text("Host:a\015\015\012");
      send_end(1'b0);
      send_text("Hos");
      send_end(1'b1);
      send_text("Host: a  b\t\015\012");
      send_end(1'b0);
      send_text("Host:[]\015\012");
      send_end(1'b0);
      send_text("Host::x\015\012");
      send_end(1'b1);
      send_text("Hostx: y\015\012\015\012");
      send_end(1'b0);
      send_text("Host:\377\200Q\015\012");
      send_end(1'b0);
      send_text("Host:zz");
      send_end(1'b0);
   endtask

   // Smallest and largest limits, a limit beyond the store, and a write to
   // an address where no register lives.
   task automatic test_limit_extremes();
      write_register(LIMIT_ADDR, 0);
      send_host_of_length(1);
      write_register(LIMIT_ADDR, 1);
      send_host_of_length(1);
      send_host_of_length(2);
      write_register(LIMIT_ADDR, STORE_DEPTH);
      send_host_of_length(STORE_DEPTH);
      write_register(LIMIT_ADDR, (1 << LIMIT_W) - 1);
      send_host_of_length(STORE_DEPTH + 1);
      write_register(UNUSED_ADDR, 5);
      write_register(LIMIT_ADDR, HOST_LIMIT_RST);
   endtask

   // The result side stops for a long stretch while host names keep
   // coming, so the queue inside fills and the request side stalls.
   task automatic test_backpressure();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_off_cycles = 400;
      repeat (2) send_host_of_length(20);
      wait_idle();
   endtask

   // Random requests in three idling phases, with limit changes between
   // requests now and then.
   task automatic test_random_requests();
      int goal;
      for (int stage = 0; stage < 3; stage++) begin
         case (stage)
            0: begin
               tx_idle_pct = 25;
               rx_idle_pct = 80;
            end
            1: begin
               tx_idle_pct = 80;
               rx_idle_pct = 25;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         goal = words_offered + 30;
         while (words_offered < goal) begin
            if ($urandom_range(7) == 0) write_register(LIMIT_ADDR, random_limit());
            send_random_request();
         end
      end
   endtask

   initial begin
      new_request();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      tx_idle_pct = 25;
      rx_idle_pct = 80;
      test_reset_limit();
      test_header_forms();
      test_limit_extremes();
      test_backpressure();
      test_random_requests();
      wait_idle();
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // A stuck handshake or a result that never comes ends the run here.
   initial begin
      #10_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule

// ----- files.f -----
src/hhe_pkg.sv
src/hhe_ram.sv
src/hhe_front.sv
src/hhe_cmd_fifo.sv
src/hhe_back.sv
src/http_host_header_extractor.sv
verif/testbench.sv
